FILE: rtl/bclt_pkg.sv
// Shared constants, types and helpers for the blocked card list table.
`default_nettype none

package bclt_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PTR_W       = 6;
    localparam int CARD_W      = 32;
    localparam int OUT_SLOT_W  = 5;

    localparam logic [PTR_W-1:0]  PTR_ERASED  = {PTR_W{1'b1}};
    localparam logic [CARD_W-1:0] CARD_ERASED = {CARD_W{1'b1}};
    localparam logic [CARD_W-1:0] CARD_CLEAR  = {CARD_W{1'b0}};

    localparam logic MODE_BLOCK   = 1'b0;
    localparam logic MODE_UNBLOCK = 1'b1;

    // Memory access issued by the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [CARD_W-1:0] wr_data;
    } mem_req_t;

    // One result beat
    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot_index;
        logic                  changed;
        logic                  was_listed;
    } result_t;

    // Reduce a slot number to the low bits reported on the result
    function automatic logic [OUT_SLOT_W-1:0] out_slot(input logic [SLOT_W-1:0] s);
        logic [OUT_SLOT_W+SLOT_W-1:0] w;
        w = {{OUT_SLOT_W{1'b0}}, s};
        return w[OUT_SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bclt_mem.sv
// Card table memory: one read and one write port, registered read, per-slot valid bits.
`default_nettype none

module bclt_mem
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bclt_pkg::mem_req_t           req,
    output logic [bclt_pkg::CARD_W-1:0]       rd_data
);

    logic [bclt_pkg::CARD_W-1:0]      card_mem [bclt_pkg::TABLE_SLOTS];
    logic [bclt_pkg::TABLE_SLOTS-1:0] vld_reg;
    logic [bclt_pkg::CARD_W-1:0]      data_reg;
    logic                             rd_vld_reg;

    // Write the array and register the read data
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            card_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= card_mem[req.rd_addr];
        end
    end

    // Track written slots; an unwritten slot reads as erased
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? data_reg : bclt_pkg::CARD_ERASED;

endmodule

`default_nettype wire

FILE: rtl/bclt_seq.sv
// Request sequencer: scans the table, decides the update, writes back, builds the result.
`default_nettype none

module bclt_seq
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_mode,
    input  wire logic [bclt_pkg::CARD_W-1:0] in_card,
    output bclt_pkg::mem_req_t               mem_req,
    input  wire logic [bclt_pkg::CARD_W-1:0] rd_data,
    output logic                             res_valid,
    output bclt_pkg::result_t                res,
    input  wire logic                        res_take
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            mode_reg, mode_next;
    logic [bclt_pkg::CARD_W-1:0]     card_reg, card_next;
    logic [bclt_pkg::SLOT_W-1:0]     cnt_reg, cnt_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [bclt_pkg::SLOT_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                            hit_reg, hit_next;
    logic [bclt_pkg::SLOT_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [bclt_pkg::PTR_W-1:0]      ptr_reg, ptr_next;
    bclt_pkg::result_t               res_reg, res_next;
    logic [bclt_pkg::PTR_W-1:0]      ptr_wrap;
    logic                            scan_last;
    logic                            accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;
    assign scan_last = (cnt_reg == bclt_pkg::SLOT_W'(bclt_pkg::TABLE_SLOTS - 1));

    // Wrap an exhausted or erased fill pointer back to the first slot
    assign ptr_wrap = ((ptr_reg == bclt_pkg::PTR_ERASED) ||
                       (ptr_reg >= bclt_pkg::PTR_W'(bclt_pkg::TABLE_SLOTS))) ?
                      '0 : ptr_reg;

    // Next-state, scan, compare and update logic
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        card_next    = card_reg;
        cnt_next     = cnt_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cnt_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        ptr_next     = ptr_reg;
        res_next     = res_reg;
        mem_req      = '0;
        mem_req.rd_addr = cnt_reg;

        // Record the first matching slot as read data returns
        if (cmp_vld_reg && !hit_reg && (rd_data == card_reg))
        begin
            hit_next     = 1'b1;
            hit_idx_next = cmp_idx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_mode;
                    card_next  = in_card;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_req.rd_en = 1'b1;
                cmp_vld_next  = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                res_next.was_listed = hit_reg;
                res_next.changed    = 1'b0;
                res_next.slot_index = '0;
                if (mode_reg == bclt_pkg::MODE_BLOCK)
                begin
                    if (!hit_reg)
                    begin
                        mem_req.wr_en       = 1'b1;
                        mem_req.wr_addr     = ptr_wrap[bclt_pkg::SLOT_W-1:0];
                        mem_req.wr_data     = card_reg;
                        ptr_next            = ptr_wrap + 1'b1;
                        res_next.changed    = 1'b1;
                        res_next.slot_index =
                            bclt_pkg::out_slot(ptr_wrap[bclt_pkg::SLOT_W-1:0]);
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        mem_req.wr_en       = 1'b1;
                        mem_req.wr_addr     = hit_idx_reg;
                        mem_req.wr_data     = bclt_pkg::CARD_CLEAR;
                        res_next.changed    = 1'b1;
                        res_next.slot_index = bclt_pkg::out_slot(hit_idx_reg);
                    end
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            ptr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            ptr_reg     <= ptr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        card_reg    <= card_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

FILE: rtl/blocked_card_list_table.sv
// Top level of the blocked card list table: stream ports, sequencer, memory, output register.
// An accepted request is scanned through the single memory read port, one slot per cycle,
// then passes the drain, update and result steps before m_tvalid; a new request is accepted
// only after the previous result beat has been taken into the output register.
// Reset: asynchronous, active low; all slots read as erased (all ones) through per-slot
// valid bits and the fill pointer is zero; the block is ready right after reset.
`default_nettype none

module blocked_card_list_table
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] card_id
    input  wire logic [0:0]  s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] was_listed, [1] changed, [6:2] slot_index, [7] zero
);

    bclt_pkg::mem_req_t                mem_req;
    logic [bclt_pkg::CARD_W-1:0]       rd_data;
    logic                              res_valid;
    bclt_pkg::result_t                 res;
    logic                              res_take;
    logic                              m_tvalid_reg, m_tvalid_next;
    bclt_pkg::result_t                 out_reg;

    bclt_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser[0]),
        .in_card   (s_tdata),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    bclt_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Load the output register when it is empty or being drained
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_take)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

`default_nettype wire

FILE: rtl/bclt_chk.sv
// Port-level checks for the blocked card list table, bound to the top level.
`default_nettype none

module bclt_chk
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // An unchanged table reports slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[6:2] == 5'd0)
        else $error("slot_index nonzero without a change");

    // Padding bit stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[7])
        else $error("padding bit set on result beat");

    // One request at a time: the input closes after an accepted beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while scan in progress");

endmodule

bind blocked_card_list_table bclt_chk u_bclt_chk (.*);

`default_nettype wire
